// File: rtl/core/ascb_pkg.sv
`default_nettype none

package ascb_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAKER_VERSION  = 3'd0,
        CFG_NATIVE_VERSION = 3'd1,
        CFG_MAKER_MAX_TTL  = 3'd2,
        CFG_NATIVE_MAX_TTL = 3'd3,
        CFG_REQUIRED_CAPS  = 3'd4,
        CFG_FORBIDDEN_CAPS = 3'd5
    } cfg_idx_t;

    localparam logic [7:0]  MAKER_VERSION_RST  = 8'd1;
    localparam logic [7:0]  NATIVE_VERSION_RST = 8'd2;
    localparam logic [31:0] MAKER_MAX_TTL_RST  = 32'd30000;
    localparam logic [31:0] NATIVE_MAX_TTL_RST = 32'd300000;

    localparam logic [1:0] KIND_CMD      = 2'd0;
    localparam logic [1:0] KIND_CMD_BAD  = 2'd1;
    localparam logic [1:0] KIND_POLL     = 2'd2;

    localparam logic [7:0]  STATE_IDLE    = 8'd0;
    localparam logic [7:0]  STATE_MAX     = 8'd4;
    localparam logic [31:0] WORD_ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OUT_DISPATCHED    = 3'd0,
        OUT_MALFORMED     = 3'd1,
        OUT_DROPPED       = 3'd2,
        OUT_DUPLICATE     = 3'd3,
        OUT_EXPIRED       = 3'd4,
        OUT_NOTHING       = 3'd5,
        OUT_EPOCH_CHANGED = 3'd6
    } outcome_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  version;
        logic [7:0]  state_code;
        logic [15:0] reserved_bytes;
        logic [31:0] trans_num;
        logic [31:0] ttl_ms;
        logic [31:0] src_hash;
        logic [31:0] epoch_num;
        logic [31:0] now_ms;
        logic        link_connected;
        logic [31:0] link_capabilities;
        logic [31:0] restart_cnt;
    } in_beat_t;

    typedef struct packed {
        logic        dispatch_valid;
        logic [2:0]  dispatch_state;
        logic [31:0] dispatch_transition;
        logic        expiry_flag;
        outcome_t    outcome;
    } out_beat_t;

endpackage

`default_nettype wire

// File: rtl/core/agent_state_command_bridge_unit.sv
// Agent state command bridge.
// Input channel (s_valid/s_ready): one beat is either a command (kind 0, 1 or 3)
// or a poll tick (kind 2), carrying the payload and the current USB epoch,
// time and link status. Output channel (m_valid/m_ready): exactly one result
// beat per input beat, in order, with dispatch fields and an outcome code.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write one register per cycle;
// only write while the block is idle.
// Path: a beat accepted into the input register sits there, is evaluated against
// the bridge state and lands in the output register as soon as that register is free.
// Throughput: one beat per cycle while m_ready is high; the evaluation is a single
// pass of compares, a TTL clamp and the deadline add between the two registers.
// Stall: when m_ready is low the result is held; the input register still
// takes one more beat, after which s_ready drops until the output drains.
// Reset (aresetn low, synchronous): both registers empty, configuration back
// to its defaults, no last command, expiry disarmed, session epoch zero.
`default_nettype none

module agent_state_command_bridge_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_wr_en,
    input  wire logic [ascb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ascb_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_kind,
    input  wire logic [7:0]                        s_version,
    input  wire logic [7:0]                        s_state_code,
    input  wire logic [15:0]                       s_reserved_bytes,
    input  wire logic [31:0]                       s_transition_id,
    input  wire logic [31:0]                       s_ttl_ms,
    input  wire logic [31:0]                       s_source_hash,
    input  wire logic [31:0]                       s_usb_epoch,
    input  wire logic [31:0]                       s_now_ms,
    input  wire logic                              s_link_connected,
    input  wire logic [31:0]                       s_link_capabilities,
    input  wire logic [31:0]                       s_peer_restarts,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_dispatch_valid,
    output logic [2:0]                             m_dispatch_state,
    output logic [31:0]                            m_dispatch_transition,
    output logic                                   m_ttl_expiry,
    output logic [2:0]                             m_outcome
);
    import ascb_pkg::*;

    // configuration
    logic [7:0]  maker_version_reg;
    logic [7:0]  native_version_reg;
    logic [31:0] maker_max_ttl_reg;
    logic [31:0] native_max_ttl_reg;
    logic [31:0] required_caps_reg;
    logic [31:0] forbidden_caps_reg;

    // pipeline
    logic      in_valid_reg;
    in_beat_t  in_beat_reg;
    logic      out_valid_reg;
    out_beat_t out_beat_reg;
    out_beat_t out_beat_next;
    logic      out_free;
    logic      advance;

    // bridge state
    logic [31:0] session_epoch_reg, session_epoch_next;
    logic        last_valid_reg, last_valid_next;
    logic [7:0]  last_version_reg, last_version_next;
    logic [2:0]  last_state_reg, last_state_next;
    logic [31:0] last_transition_reg, last_transition_next;
    logic [31:0] last_ttl_reg, last_ttl_next;
    logic [31:0] last_hash_reg, last_hash_next;
    logic [31:0] restarts_at_command_reg, restarts_at_command_next;
    logic        expiry_armed_reg, expiry_armed_next;
    logic [31:0] expiry_deadline_reg, expiry_deadline_next;
    logic [31:0] expiry_transition_reg, expiry_transition_next;

    // evaluation terms
    logic        epoch_same;
    logic        link_up;
    logic        restarted;
    logic        deadline_hit;
    logic [31:0] since_deadline;
    logic        base_ok;
    logic        is_maker;
    logic        is_native;
    logic        native_ttl_ok;
    logic        cmd_ok;
    logic [31:0] maker_ttl;
    logic [31:0] eff_ttl;
    logic        is_dup;
    logic        st_idle;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            maker_version_reg  <= MAKER_VERSION_RST;
            native_version_reg <= NATIVE_VERSION_RST;
            maker_max_ttl_reg  <= MAKER_MAX_TTL_RST;
            native_max_ttl_reg <= NATIVE_MAX_TTL_RST;
            required_caps_reg  <= '0;
            forbidden_caps_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAKER_VERSION:  maker_version_reg  <= cfg_wdata[7:0];
                CFG_NATIVE_VERSION: native_version_reg <= cfg_wdata[7:0];
                CFG_MAKER_MAX_TTL:  maker_max_ttl_reg  <= cfg_wdata;
                CFG_NATIVE_MAX_TTL: native_max_ttl_reg <= cfg_wdata;
                CFG_REQUIRED_CAPS:  required_caps_reg  <= cfg_wdata;
                CFG_FORBIDDEN_CAPS: forbidden_caps_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= '{kind:              s_kind,
                             version:           s_version,
                             state_code:        s_state_code,
                             reserved_bytes:    s_reserved_bytes,
                             trans_num:         s_transition_id,
                             ttl_ms:            s_ttl_ms,
                             src_hash:          s_source_hash,
                             epoch_num:         s_usb_epoch,
                             now_ms:            s_now_ms,
                             link_connected:    s_link_connected,
                             link_capabilities: s_link_capabilities,
                             restart_cnt:       s_peer_restarts};
        end
    end

    always_comb begin
        epoch_same = (in_beat_reg.epoch_num == session_epoch_reg);
        link_up    = in_beat_reg.link_connected
                  && ((in_beat_reg.link_capabilities & required_caps_reg) == required_caps_reg)
                  && ((in_beat_reg.link_capabilities & forbidden_caps_reg) == 32'd0);
        restarted      = last_valid_reg
                      && (in_beat_reg.restart_cnt != restarts_at_command_reg);
        since_deadline = in_beat_reg.now_ms - expiry_deadline_reg;
        deadline_hit   = !since_deadline[31];

        st_idle   = (in_beat_reg.state_code == STATE_IDLE);
        base_ok   = (in_beat_reg.kind == KIND_CMD)
                 && (in_beat_reg.epoch_num != 32'd0)
                 && (in_beat_reg.reserved_bytes == 16'd0)
                 && (in_beat_reg.trans_num != 32'd0)
                 && (in_beat_reg.state_code <= STATE_MAX);
        is_maker  = (in_beat_reg.version == maker_version_reg);
        is_native = !is_maker && (in_beat_reg.version == native_version_reg);
        native_ttl_ok = st_idle ? (in_beat_reg.ttl_ms == 32'd0)
                                : ((in_beat_reg.ttl_ms != 32'd0)
                                   && (in_beat_reg.ttl_ms <= native_max_ttl_reg));
        cmd_ok    = base_ok && (is_maker || (is_native && native_ttl_ok));

        maker_ttl = (in_beat_reg.ttl_ms > maker_max_ttl_reg) ? maker_max_ttl_reg
                                                             : in_beat_reg.ttl_ms;
        if (is_maker) begin
            eff_ttl = st_idle ? 32'd0 : maker_ttl;
        end else begin
            eff_ttl = in_beat_reg.ttl_ms;
        end

        is_dup = epoch_same && last_valid_reg
              && (last_version_reg == in_beat_reg.version)
              && (in_beat_reg.state_code[7:3] == 5'd0)
              && (last_state_reg == in_beat_reg.state_code[2:0])
              && (last_transition_reg == in_beat_reg.trans_num)
              && (last_ttl_reg == eff_ttl)
              && (last_hash_reg == in_beat_reg.src_hash);
    end

    always_comb begin
        session_epoch_next       = session_epoch_reg;
        last_valid_next          = last_valid_reg;
        last_version_next        = last_version_reg;
        last_state_next          = last_state_reg;
        last_transition_next     = last_transition_reg;
        last_ttl_next            = last_ttl_reg;
        last_hash_next           = last_hash_reg;
        restarts_at_command_next = restarts_at_command_reg;
        expiry_armed_next        = expiry_armed_reg;
        expiry_deadline_next     = expiry_deadline_reg;
        expiry_transition_next   = expiry_transition_reg;

        out_beat_next = '{dispatch_valid:      1'b0,
                          dispatch_state:      3'd0,
                          dispatch_transition: 32'd0,
                          expiry_flag:         1'b0,
                          outcome:             OUT_NOTHING};

        if (in_beat_reg.kind == KIND_POLL) begin
            if (!epoch_same) begin
                session_epoch_next    = in_beat_reg.epoch_num;
                last_valid_next       = 1'b0;
                expiry_armed_next     = 1'b0;
                out_beat_next.outcome = OUT_EPOCH_CHANGED;
            end else if (!link_up || restarted) begin
                last_valid_next       = 1'b0;
                expiry_armed_next     = 1'b0;
                out_beat_next.outcome = (last_valid_reg || expiry_armed_reg) ? OUT_DROPPED
                                                                             : OUT_NOTHING;
            end else if (expiry_armed_reg && deadline_hit) begin
                expiry_armed_next                 = 1'b0;
                out_beat_next.dispatch_valid      = 1'b1;
                out_beat_next.dispatch_transition = expiry_transition_reg;
                out_beat_next.expiry_flag         = 1'b1;
                out_beat_next.outcome             = OUT_EXPIRED;
            end
        end else begin
            if (!epoch_same) begin
                session_epoch_next = in_beat_reg.epoch_num;
                last_valid_next    = 1'b0;
                expiry_armed_next  = 1'b0;
            end
            if (!cmd_ok) begin
                out_beat_next.outcome = OUT_MALFORMED;
            end else if (!link_up) begin
                last_valid_next       = 1'b0;
                expiry_armed_next     = 1'b0;
                out_beat_next.outcome = OUT_DROPPED;
            end else if (is_dup) begin
                out_beat_next.outcome = OUT_DUPLICATE;
            end else begin
                last_valid_next          = 1'b1;
                last_version_next        = in_beat_reg.version;
                last_state_next          = in_beat_reg.state_code[2:0];
                last_transition_next     = in_beat_reg.trans_num;
                last_ttl_next            = eff_ttl;
                last_hash_next           = in_beat_reg.src_hash;
                restarts_at_command_next = in_beat_reg.restart_cnt;
                expiry_armed_next        = !st_idle && (eff_ttl != 32'd0);
                expiry_deadline_next     = in_beat_reg.now_ms + eff_ttl;
                expiry_transition_next   = (in_beat_reg.trans_num == WORD_ALL_ONES)
                                         ? 32'd1 : in_beat_reg.trans_num + 32'd1;
                out_beat_next.dispatch_valid      = 1'b1;
                out_beat_next.dispatch_state      = in_beat_reg.state_code[2:0];
                out_beat_next.dispatch_transition = in_beat_reg.trans_num;
                out_beat_next.outcome             = OUT_DISPATCHED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            session_epoch_reg <= '0;
            last_valid_reg    <= 1'b0;
            expiry_armed_reg  <= 1'b0;
        end else if (advance) begin
            session_epoch_reg <= session_epoch_next;
            last_valid_reg    <= last_valid_next;
            expiry_armed_reg  <= expiry_armed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_version_reg        <= '0;
            last_state_reg          <= '0;
            last_transition_reg     <= '0;
            last_ttl_reg            <= '0;
            last_hash_reg           <= '0;
            restarts_at_command_reg <= '0;
            expiry_deadline_reg     <= '0;
            expiry_transition_reg   <= '0;
        end else if (advance) begin
            last_version_reg        <= last_version_next;
            last_state_reg          <= last_state_next;
            last_transition_reg     <= last_transition_next;
            last_ttl_reg            <= last_ttl_next;
            last_hash_reg           <= last_hash_next;
            restarts_at_command_reg <= restarts_at_command_next;
            expiry_deadline_reg     <= expiry_deadline_next;
            expiry_transition_reg   <= expiry_transition_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_beat_reg <= out_beat_next;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_dispatch_valid      = out_beat_reg.dispatch_valid;
    assign m_dispatch_state      = out_beat_reg.dispatch_state;
    assign m_dispatch_transition = out_beat_reg.dispatch_transition;
    assign m_ttl_expiry          = out_beat_reg.expiry_flag;
    assign m_outcome             = out_beat_reg.outcome;

    // an armed expiry always belongs to a held command
    assert property (@(posedge aclk) disable iff (!aresetn)
        expiry_armed_reg |-> last_valid_reg)
        else $error("expiry armed without a held command");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_dispatch_valid) |->
            (m_outcome == OUT_DISPATCHED || m_outcome == OUT_EXPIRED))
        else $error("dispatch with non-dispatch outcome");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ttl_expiry) |->
            (m_dispatch_valid && m_dispatch_state == 3'd0 && m_outcome == OUT_EXPIRED))
        else $error("expiry beat is not an idle dispatch");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (!advance && !$past(!aresetn)) |=> $stable(session_epoch_reg))
        else $error("state changed without an evaluated beat");

endmodule

`default_nettype wire
